// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

	// Default geometry of the converter and the averaging window.
	localparam int ADC_BITS_DEF         = 10;
	localparam int MAX_SAMPLES_LOG2_DEF = 4;

	// Event codes carried on the opcode field.
	localparam logic [1:0] OP_TOUCH_IRQ = 2'd0;
	localparam logic [1:0] OP_CONV_DONE = 2'd1;
	localparam logic [1:0] OP_TIMER     = 2'd2;
	localparam logic [1:0] OP_READ      = 2'd3;

	// Panel modes.
	localparam logic [1:0] MODE_WAIT_DOWN = 2'd0;
	localparam logic [1:0] MODE_WAIT_UP   = 2'd1;
	localparam logic [1:0] MODE_AUTO      = 2'd2;

	// Configuration register indexes and widths.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 3;
	localparam int LOG2_CFG_W  = 3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLES_LOG2 = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_LAST    = 1'd1;
	localparam logic [LOG2_CFG_W-1:0]  SAMPLES_LOG2_RST = 3'd2;

	// Narrow fields of one result item.
	typedef struct packed {
		logic [1:0] panel_mode;
		logic       start_conversion;
		logic       read_valid;
		logic       read_pressure;
	} result_ctl_t;

endpackage

// ===== rtl/tsc_core.sv =====
module tsc_core #(
	parameter int ADC_BITS         = tsc_pkg::ADC_BITS_DEF,
	parameter int MAX_SAMPLES_LOG2 = tsc_pkg::MAX_SAMPLES_LOG2_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [1:0]                        opcode,
	input  logic                              pen_up,
	input  logic [ADC_BITS-1:0]               x_sample,
	input  logic [ADC_BITS-1:0]               y_sample,
	input  logic [tsc_pkg::LOG2_CFG_W-1:0]    samples_log2,
	input  logic                              hold_last,
	output tsc_pkg::result_ctl_t              res_ctl,
	output logic [ADC_BITS-1:0]               res_x,
	output logic [ADC_BITS-1:0]               res_y
);
	import tsc_pkg::*;

	localparam int CNT_W = MAX_SAMPLES_LOG2 + 1;
	localparam int SUM_W = ADC_BITS + MAX_SAMPLES_LOG2;
	localparam int K_W   = $clog2(MAX_SAMPLES_LOG2 + 1);
	localparam logic [LOG2_CFG_W-1:0] MAX_K = LOG2_CFG_W'(MAX_SAMPLES_LOG2);

	// Architectural state.
	logic [1:0]          mode_q, mode_d;
	logic                resample_q, resample_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [SUM_W-1:0]    sum_x_q, sum_x_d, sum_y_q, sum_y_d;
	logic                mb_full_q, mb_full_d;
	logic [ADC_BITS-1:0] mb_x_q, mb_x_d, mb_y_q, mb_y_d;
	logic                mb_p_q, mb_p_d;
	logic [ADC_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

	// Datapath for one conversion.
	logic [K_W-1:0]      k;
	logic [SUM_W-1:0]    sum_x_add, sum_y_add, avg_x, avg_y;
	logic [CNT_W-1:0]    count_inc, target;
	logic                batch_done;
	logic [ADC_BITS-1:0] avg_x_sat, avg_y_sat;

	// Report posting and read selection.
	logic                post;
	logic [ADC_BITS-1:0] post_x, post_y;
	logic                post_p;
	logic                use_last;
	logic                mb_load;

	// A window larger than supported acts as the largest one.
	assign k = (samples_log2 > MAX_K) ? K_W'(MAX_SAMPLES_LOG2) : K_W'(samples_log2);

	assign sum_x_add  = sum_x_q + SUM_W'(x_sample);
	assign sum_y_add  = sum_y_q + SUM_W'(y_sample);
	assign count_inc  = count_q + CNT_W'(1);
	assign target     = CNT_W'(1) << k;
	assign batch_done = (count_inc >= target);
	assign avg_x      = sum_x_add >> k;
	assign avg_y      = sum_y_add >> k;

	// The average saturates when the window was narrowed during a batch.
	assign avg_x_sat = (|avg_x[SUM_W-1:ADC_BITS]) ? {ADC_BITS{1'b1}} : avg_x[ADC_BITS-1:0];
	assign avg_y_sat = (|avg_y[SUM_W-1:ADC_BITS]) ? {ADC_BITS{1'b1}} : avg_y[ADC_BITS-1:0];

	assign use_last = hold_last && ((mb_x_q == '0) || (mb_y_q == '0));

	// Event decode and next state.
	always_comb begin
		mode_d     = mode_q;
		resample_d = resample_q;
		count_d    = count_q;
		sum_x_d    = sum_x_q;
		sum_y_d    = sum_y_q;
		mb_full_d  = mb_full_q;
		last_x_d   = last_x_q;
		last_y_d   = last_y_q;
		post       = 1'b0;
		post_x     = '0;
		post_y     = '0;
		post_p     = 1'b0;
		res_ctl    = '0;
		res_x      = '0;
		res_y      = '0;
		case (opcode)
			OP_TOUCH_IRQ: begin
				if (pen_up) begin
					mode_d = MODE_WAIT_DOWN;
					post   = 1'b1;
				end else begin
					mode_d                   = MODE_AUTO;
					res_ctl.start_conversion = 1'b1;
				end
			end
			OP_CONV_DONE: begin
				if (pen_up) begin
					count_d    = '0;
					sum_x_d    = '0;
					sum_y_d    = '0;
					resample_d = 1'b0;
					mode_d     = MODE_WAIT_DOWN;
					post       = 1'b1;
				end else if (batch_done) begin
					post       = 1'b1;
					post_x     = avg_x_sat;
					post_y     = avg_y_sat;
					post_p     = 1'b1;
					count_d    = '0;
					sum_x_d    = '0;
					sum_y_d    = '0;
					mode_d     = MODE_WAIT_UP;
					resample_d = 1'b1;
				end else begin
					count_d                  = count_inc;
					sum_x_d                  = sum_x_add;
					sum_y_d                  = sum_y_add;
					mode_d                   = MODE_AUTO;
					res_ctl.start_conversion = 1'b1;
				end
			end
			OP_TIMER: begin
				if (resample_q && (mode_q != MODE_AUTO)) begin
					if (!pen_up) begin
						mode_d                   = MODE_AUTO;
						res_ctl.start_conversion = 1'b1;
					end else begin
						resample_d = 1'b0;
						mode_d     = MODE_WAIT_DOWN;
						post       = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (mb_full_q) begin
					mb_full_d          = 1'b0;
					res_ctl.read_valid = 1'b1;
					if (use_last) begin
						res_x = last_x_q;
						res_y = last_y_q;
					end else begin
						res_x                 = mb_x_q;
						res_y                 = mb_y_q;
						res_ctl.read_pressure = mb_p_q;
					end
					last_x_d = res_x;
					last_y_d = res_y;
				end
			end
			default: begin
				mode_d = mode_q;
			end
		endcase
		res_ctl.panel_mode = mode_d;
	end

	// A report is dropped while the mailbox still holds one.
	assign mb_load = post && !mb_full_q;

	always_comb begin
		mb_x_d = mb_x_q;
		mb_y_d = mb_y_q;
		mb_p_d = mb_p_q;
		if (mb_load) begin
			mb_x_d = post_x;
			mb_y_d = post_y;
			mb_p_d = post_p;
		end
	end

	// State registers, updated once per transferred event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_WAIT_DOWN;
			resample_q <= 1'b0;
			count_q    <= '0;
			sum_x_q    <= '0;
			sum_y_q    <= '0;
			mb_full_q  <= 1'b0;
			mb_x_q     <= '0;
			mb_y_q     <= '0;
			mb_p_q     <= 1'b0;
			last_x_q   <= '0;
			last_y_q   <= '0;
		end else if (fire) begin
			mode_q     <= mode_d;
			resample_q <= resample_d;
			count_q    <= count_d;
			sum_x_q    <= sum_x_d;
			sum_y_q    <= sum_y_d;
			last_x_q   <= last_x_d;
			last_y_q   <= last_y_d;
			mb_full_q  <= mb_load ? 1'b1 : mb_full_d;
			mb_x_q     <= mb_x_d;
			mb_y_q     <= mb_y_d;
			mb_p_q     <= mb_p_d;
		end
	end

endmodule

// ===== rtl/touchscreen_sample_controller_top.sv =====
// Resistive touchscreen sequencer. Each input transfer carries one event (touch interrupt,
// conversion done, timer tick or report read) and yields exactly one result transfer with
// the panel mode after the event, a conversion start strobe and, on a read, the mailbox
// report. Conversions are summed until 2^samples_log2 (at most 2^MAX_SAMPLES_LOG2) have
// arrived, then the average is posted with pressure 1; a pen-up posts zeros. The block takes
// one event per clock: an event is held in the input register, then the event logic
// updates the state and loads the result register, from which the result is presented.
// The input stalls only while out_ready is low and both registers are occupied.
// Configuration registers are written through the cfg channel, which is always ready;
// write them only while idle.
module touchscreen_sample_controller_top #(
	parameter int ADC_BITS         = tsc_pkg::ADC_BITS_DEF,
	parameter int MAX_SAMPLES_LOG2 = tsc_pkg::MAX_SAMPLES_LOG2_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic                             pen_up,
	input  logic [ADC_BITS-1:0]              x_sample,
	input  logic [ADC_BITS-1:0]              y_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       panel_mode,
	output logic                             start_conversion,
	output logic                             read_valid,
	output logic [ADC_BITS-1:0]              read_x,
	output logic [ADC_BITS-1:0]              read_y,
	output logic                             read_pressure
);
	import tsc_pkg::*;

	logic [LOG2_CFG_W-1:0] samples_log2_q;
	logic                  hold_last_q;

	logic                  valid_s1;
	logic [1:0]            opcode_s1;
	logic                  pen_up_s1;
	logic [ADC_BITS-1:0]   x_sample_s1, y_sample_s1;

	logic                  valid_s2;
	result_ctl_t           ctl_s2;
	logic [ADC_BITS-1:0]   x_s2, y_s2;

	result_ctl_t           res_ctl;
	logic [ADC_BITS-1:0]   res_x, res_y;
	logic                  advance, fire;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_log2_q <= SAMPLES_LOG2_RST;
			hold_last_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLES_LOG2: samples_log2_q <= cfg_data[LOG2_CFG_W-1:0];
				CFG_HOLD_LAST:    hold_last_q    <= cfg_data[0];
				default:          hold_last_q    <= hold_last_q;
			endcase
		end
	end

	// Flow control: the result register frees when it is empty or being taken.
	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1   <= opcode;
			pen_up_s1   <= pen_up;
			x_sample_s1 <= x_sample;
			y_sample_s1 <= y_sample;
		end
	end

	tsc_core #(
		.ADC_BITS         (ADC_BITS),
		.MAX_SAMPLES_LOG2 (MAX_SAMPLES_LOG2)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.opcode       (opcode_s1),
		.pen_up       (pen_up_s1),
		.x_sample     (x_sample_s1),
		.y_sample     (y_sample_s1),
		.samples_log2 (samples_log2_q),
		.hold_last    (hold_last_q),
		.res_ctl      (res_ctl),
		.res_x        (res_x),
		.res_y        (res_y)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ctl_s2 <= res_ctl;
			x_s2   <= res_x;
			y_s2   <= res_y;
		end
	end

	assign out_valid        = valid_s2;
	assign panel_mode       = ctl_s2.panel_mode;
	assign start_conversion = ctl_s2.start_conversion;
	assign read_valid       = ctl_s2.read_valid;
	assign read_pressure    = ctl_s2.read_pressure;
	assign read_x           = x_s2;
	assign read_y           = y_s2;

endmodule
